// ----- rtl/cfe_pkg.sv -----
// Shared types and constants for the continued-fraction expander.
package cfe_pkg;
  localparam int unsigned MaxTermsDefault = 64;
  localparam int unsigned NumW  = 32;
  localparam int unsigned DenW  = 31;
  localparam int unsigned CnW   = 34;
  localparam int unsigned CdW   = 33;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic signed [NumW-1:0] numerator;
    logic        [DenW-1:0] denominator;
  } job_t;

  typedef struct packed {
    logic                   truncated;
    logic                   is_empty;
    logic                   is_last;
    logic        [IdxW-1:0] term_index;
    logic        [CdW-1:0]  prev_den;
    logic signed [CnW-1:0]  prev_num;
    logic        [CdW-1:0]  conv_den;
    logic signed [CnW-1:0]  conv_num;
    logic signed [NumW-1:0] term;
  } res_t;
endpackage

// ----- rtl/cfe_front.sv -----
// Input stage and small job queue ahead of the expansion engine.
module cfe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfe_pkg::job_t in_job,
  output logic          job_valid,
  input  logic          job_ready,
  output cfe_pkg::job_t job
);
  localparam int unsigned PtrW = $clog2(cfe_pkg::QDepth);
  cfe_pkg::job_t mem [cfe_pkg::QDepth];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0]   count;
  logic push, pop;

  assign in_ready  = (count != (PtrW+1)'(cfe_pkg::QDepth));
  assign job_valid = (count != '0);
  assign job       = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_job;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ----- rtl/cfe_back.sv -----
// Expansion engine: bit-serial floor division and convergent update.
module cfe_back #(
  parameter int unsigned MAX_TERMS = cfe_pkg::MaxTermsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  cfe_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_ready,
  output cfe_pkg::res_t res
);
  localparam int unsigned W = cfe_pkg::NumW;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIX, S_MUL, S_OUT} state_t;
  state_t state;
  // Magnitude division of |p| by q, then floor correction for negative p.
  logic [W-1:0] pmag, quo, rem, q;
  logic         pneg;
  logic [5:0]   bitcnt;
  logic signed [W-1:0] d, rr, p;
  logic signed [cfe_pkg::CnW-1:0] cn, pn;
  logic [cfe_pkg::CdW-1:0] cd, pd;
  logic [cfe_pkg::IdxW:0] k;
  logic [W:0] trial;
  logic [W-1:0] rem_sh;
  logic signed [cfe_pkg::CnW-1:0] mn;
  logic [cfe_pkg::CdW-1:0] md;

  assign job_ready = (state == S_IDLE) && !res_valid;
  assign rem_sh = {rem[W-2:0], pmag[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.denominator == '0) begin
              res.term <= '0;
              res.conv_num <= '0;
              res.conv_den <= '0;
              res.prev_num <= '0;
              res.prev_den <= '0;
              res.term_index <= '0;
              res.truncated <= 1'b0;
              res.is_last <= 1'b1;
              res.is_empty <= 1'b1;
              res_valid <= 1'b1;
            end else begin
              p <= job.numerator;
              q <= W'(job.denominator);
              cn <= {{(cfe_pkg::CnW-1){1'b0}}, 1'b1};
              cd <= '0;
              pn <= '0;
              pd <= {{(cfe_pkg::CdW-1){1'b0}}, 1'b1};
              k <= '0;
              state <= S_DIV;
              pneg <= job.numerator[W-1];
              pmag <= job.numerator[W-1] ? -job.numerator : job.numerator;
              rem <= '0; bitcnt <= '0;
            end
          end
        end
        S_DIV: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
          end else begin
            rem <= rem_sh;
          end
          quo <= {quo[W-2:0], !trial[W]};
          pmag <= {pmag[W-2:0], 1'b0};
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 6'(W-1)) state <= S_FIX;
        end
        S_FIX: begin
          if (pneg && rem != '0) begin
            d <= -$signed(quo) - 1;
            rr <= $signed(q - rem);
          end else begin
            d <= pneg ? -$signed(quo) : $signed(quo);
            rr <= $signed(rem);
          end
          state <= S_MUL;
        end
        S_MUL: begin
          // Only the low bits of each product are kept, so the multipliers
          // stay at the convergent widths.
          mn <= cn * $signed({{2{d[W-1]}}, d}) + pn;
          md <= cd * {d[W-1], d} + pd;
          state <= S_OUT;
        end
        default: begin
          if (!res_valid) begin
            res.term <= d;
            res.conv_num <= mn;
            res.conv_den <= md;
            res.prev_num <= cn;
            res.prev_den <= cd;
            res.term_index <= k[cfe_pkg::IdxW-1:0];
            res.is_empty <= 1'b0;
            res.is_last <= (rr == 0) || (k == (cfe_pkg::IdxW+1)'(MAX_TERMS-1));
            res.truncated <= (rr != 0) && (k == (cfe_pkg::IdxW+1)'(MAX_TERMS-1));
            res_valid <= 1'b1;
            pn <= cn; pd <= cd;
            cn <= mn; cd <= md;
            k <= k + 1'b1;
            if ((rr == 0) || (k == (cfe_pkg::IdxW+1)'(MAX_TERMS-1))) begin
              state <= S_IDLE;
            end else begin
              p <= $signed(q);
              q <= rr;
              pneg <= q[W-1];
              pmag <= q;
              rem <= '0; bitcnt <= '0;
              state <= S_DIV;
            end
          end
        end
      endcase
    end
  end
  logic unused;
  assign unused = ^p;
endmodule

// ----- rtl/continued_fraction_expander_core.sv -----
// Top level of the continued-fraction expander.
// Usage: each input item on s_axis carries a signed numerator and a
// non-negative denominator. The block expands the rational into its
// continued fraction and sends one result item on m_axis per term, carrying
// the term, the current and previous convergents and the term index.
// The final item of an expansion has m_axis_tlast set. A zero denominator
// gives a single item flagged empty. Each term passes through the
// one-bit-per-cycle divider (32 steps), a fix-up, a multiply and an output
// step; a 32-bit rational has up to about 46 terms. A two-entry queue
// accepts new items while the engine works.
// Reset clears the queue and the engine. When the receiver stalls, the
// engine computes the next term and then waits in its output state until
// the held item has been taken.
module continued_fraction_expander_core #(
  parameter int unsigned MAX_TERMS = cfe_pkg::MaxTermsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // numerator[31:0], denominator[62:32]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,  // term[31:0], conv_num[65:32],
                                      // conv_den[98:66], prev_num[132:99],
                                      // prev_den[165:133], term_index[171:166]
  output logic         m_axis_tlast,
  output logic [1:0]   m_axis_tuser   // is_empty[0], truncated[1]
);
  cfe_pkg::job_t in_job, job;
  cfe_pkg::res_t res;
  logic job_valid, job_ready;

  assign in_job = {s_axis_tdata[31:0], s_axis_tdata[62:32]};

  cfe_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job,
    .job_valid, .job_ready, .job
  );

  cfe_back #(.MAX_TERMS(MAX_TERMS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {4'b0, res.term_index, res.prev_den, res.prev_num,
                         res.conv_den, res.conv_num, res.term};
  assign m_axis_tlast = res.is_last;
  assign m_axis_tuser = {res.truncated, res.is_empty};
  logic unused;
  assign unused = s_axis_tdata[63];
endmodule

// ----- rtl/cfe_checker.sv -----
// Port-level checks for the continued-fraction expander.
module cfe_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         m_axis_tlast,
  input logic [1:0]   m_axis_tuser,
  input logic [175:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty result not last");
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("truncated result not last");
endmodule

bind continued_fraction_expander_core cfe_port_checks u_chk (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tlast, .m_axis_tuser,
  .m_axis_tdata
);

// ----- dv/cfe_checker.sv -----
// Checker for the continued-fraction expander: predicts and compares every result item.
`timescale 1ns / 1ps
module cfe_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [175:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending_terms,
  output int           terms_seen
);
  localparam int MaxTerms = 64;

  typedef struct packed {
    logic signed [31:0] term;
    logic [33:0]        conv_num;
    logic [32:0]        conv_den;
    logic [33:0]        prev_num;
    logic [32:0]        prev_den;
    logic [5:0]         term_index;
    logic               is_last;
    logic               is_empty;
    logic               truncated;
  } term_t;

  term_t expected_terms[$];

  // Expand one rational with floor division and push one expectation per term.
  task automatic expand_rational(input logic [31:0] num_bits, input logic [30:0] den_bits);
    longint p, q, d, r;
    logic [63:0] cn, cd, pn, pd, nn, nd;
    term_t t;
    int k;
    p = longint'(signed'(num_bits));
    q = longint'(den_bits);
    t = '0;
    if (q == 0) begin
      t.is_last = 1'b1;
      t.is_empty = 1'b1;
      expected_terms.push_back(t);
      return;
    end
    cn = 64'd1; cd = 64'd0; pn = 64'd0; pd = 64'd1;
    k = 0;
    while (q != 0 && k < MaxTerms) begin
      d = p / q;
      r = p - d * q;
      if (r < 0) begin
        d = d - 1;
        r = r + q;
      end
      nn = cn * 64'(d) + pn;
      nd = cd * 64'(d) + pd;
      pn = cn; pd = cd; cn = nn; cd = nd;
      t = '0;
      t.term = d[31:0];
      t.conv_num = cn[33:0];
      t.conv_den = cd[32:0];
      t.prev_num = pn[33:0];
      t.prev_den = pd[32:0];
      t.term_index = k[5:0];
      expected_terms.push_back(t);
      k++;
      p = q;
      q = r;
    end
    t = expected_terms.pop_back();
    t.is_last = 1'b1;
    t.truncated = (q != 0);
    expected_terms.push_back(t);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t mismatch at result %0d: %s", $realtime, terms_seen, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    term_t want, got;
    if (rst) begin
      expected_terms.delete();
      fail_count = 0;
      terms_seen = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expand_rational(s_axis_tdata[31:0], s_axis_tdata[62:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.term = m_axis_tdata[31:0];
        got.conv_num = m_axis_tdata[65:32];
        got.conv_den = m_axis_tdata[98:66];
        got.prev_num = m_axis_tdata[132:99];
        got.prev_den = m_axis_tdata[165:133];
        got.term_index = m_axis_tdata[171:166];
        got.is_last = m_axis_tlast;
        got.is_empty = m_axis_tuser[0];
        got.truncated = m_axis_tuser[1];
        if (expected_terms.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_terms.pop_front();
          if (got.term !== want.term)
            report_mismatch($sformatf("term %0d, want %0d", got.term, want.term));
          if (got.conv_num !== want.conv_num)
            report_mismatch($sformatf("conv_num %h, want %h", got.conv_num, want.conv_num));
          if (got.conv_den !== want.conv_den)
            report_mismatch($sformatf("conv_den %h, want %h", got.conv_den, want.conv_den));
          if (got.prev_num !== want.prev_num)
            report_mismatch($sformatf("prev_num %h, want %h", got.prev_num, want.prev_num));
          if (got.prev_den !== want.prev_den)
            report_mismatch($sformatf("prev_den %h, want %h", got.prev_den, want.prev_den));
          if (got.term_index !== want.term_index)
            report_mismatch($sformatf("index %0d, want %0d", got.term_index, want.term_index));
          if (got.is_last !== want.is_last)
            report_mismatch($sformatf("last %b, want %b", got.is_last, want.is_last));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("empty %b, want %b", got.is_empty, want.is_empty));
          if (got.truncated !== want.truncated)
            report_mismatch($sformatf("truncated %b, want %b", got.truncated, want.truncated));
        end
        terms_seen++;
      end
    end
    pending_terms = expected_terms.size();
  end
endmodule

// ----- dv/tb.sv -----
// Testbench top for the continued-fraction expander: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;
  int           fail_count, pending_terms, terms_seen;

  localparam int RandomItems = 220;
  // Margin for computing terms under receiver stalls.
  localparam int IdleLimit = 20000;

  logic [63:0] rationals[$];
  int          idle_cycles;
  int          stall_phase;

  continued_fraction_expander_core DUT (.*);

  cfe_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] pack_rational(input logic [31:0] num, input logic [30:0] den);
    return {1'b0, den, num};
  endfunction

  // Receiver stalls follow a slowly changing mode so that both long runs of
  // ready and heavy backpressure occur.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 500) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: counts cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [31:0] n;
    logic [30:0] d;
    int gap, burst;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst = 1'b1;
    // Directed cases: extremes, zero denominator, zero numerator, negative
    // first terms, integers and long Fibonacci-like expansions.
    rationals.push_back(pack_rational(32'd7, 31'd0));
    rationals.push_back(pack_rational(32'h8000_0000, 31'd0));
    rationals.push_back(pack_rational(32'd0, 31'd5));
    rationals.push_back(pack_rational(32'd0, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(32'h7FFF_FFFF, 31'd1));
    rationals.push_back(pack_rational(32'h8000_0000, 31'd1));
    rationals.push_back(pack_rational(32'h7FFF_FFFF, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(32'h8000_0000, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(32'h7FFF_FFFE, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(-32'sd1, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(32'd1, 31'h7FFF_FFFF));
    rationals.push_back(pack_rational(32'd1836311903, 31'd1134903170));
    rationals.push_back(pack_rational(-32'sd1836311903, 31'd1134903170));
    rationals.push_back(pack_rational(32'd1134903170, 31'd1836311903));
    rationals.push_back(pack_rational(-32'sd7, 31'd3));
    rationals.push_back(pack_rational(32'd355, 31'd113));
    rationals.push_back(pack_rational(-32'sd6, 31'd3));
    rationals.push_back(pack_rational(32'hFFFF_FFFF, 31'd0));
    for (int i = 0; i < RandomItems; i++) begin
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = 31'($urandom_range(1, 16));
        2: d = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
        default: d = 31'($urandom) | 31'd1;
      endcase
      case ($urandom_range(0, 7))
        0: n = 32'($urandom_range(0, 40)) - 32'd20;
        1: n = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFFF};
        default: n = $urandom;
      endcase
      rationals.push_back(pack_rational(n, d));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Sender bursts with random gaps; some bursts have no gaps at all.
    while (rationals.size() != 0) begin
      burst = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (burst > 0 && rationals.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rationals.pop_front();
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst--;
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_terms != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Expanded %0d rationals into %0d result items.", RandomItems + 18, terms_seen);
    $display("Covered zero denominators, sign extremes and long expansions under stalls.");
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
